/* rtl/aco_pkg.sv */
// Shared types, constants and command codes of the multi-pattern occurrence counter.
`default_nettype none

package aco_pkg;

	localparam int NODES           = 4096;
	localparam int NODE_W          = 12;
	localparam int NODE_CNT_W      = 13;
	localparam int ALPHABET        = 26;
	localparam int LETTER_W        = 5;
	localparam int MAX_PATTERNS    = 1024;
	localparam int PAT_W           = 10;
	localparam int PAT_CNT_W       = 11;
	localparam int MAX_PATTERN_LEN = 8;
	localparam int DEPTH_W         = 4;
	localparam int POS_W           = 20;
	localparam int LCE_W           = POS_W + 1;
	localparam int COUNT_W         = 20;

	localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
	localparam logic [LCE_W-1:0]   FAR_BELOW = {1'b1, {POS_W{1'b0}}};

	localparam logic [2:0] OP_CLEAR   = 3'd0;
	localparam logic [2:0] OP_PATTERN = 3'd1;
	localparam logic [2:0] OP_BUILD   = 3'd2;
	localparam logic [2:0] OP_TEXT    = 3'd3;
	localparam logic [2:0] OP_QUERY   = 3'd4;

	localparam logic [1:0] ST_ANSWER    = 2'd0;
	localparam logic [1:0] ST_TRIE_FULL = 2'd1;
	localparam logic [1:0] ST_BAD_INDEX = 2'd2;

	localparam logic [2:0] CLS_NONE    = 3'd0;
	localparam logic [2:0] CLS_CLEAR   = 3'd1;
	localparam logic [2:0] CLS_PATTERN = 3'd2;
	localparam logic [2:0] CLS_BUILD   = 3'd3;
	localparam logic [2:0] CLS_TEXT    = 3'd4;
	localparam logic [2:0] CLS_QUERY   = 3'd5;

	localparam int CMD_W = 5;
	localparam logic [CMD_W-1:0] CMD_NOP         = 5'd0;
	localparam logic [CMD_W-1:0] CMD_CLR_START   = 5'd1;
	localparam logic [CMD_W-1:0] CMD_CLR_STEP    = 5'd2;
	localparam logic [CMD_W-1:0] CMD_CAPTURE     = 5'd3;
	localparam logic [CMD_W-1:0] CMD_PL_RD       = 5'd4;
	localparam logic [CMD_W-1:0] CMD_PL_EV       = 5'd5;
	localparam logic [CMD_W-1:0] CMD_PL_LAST     = 5'd6;
	localparam logic [CMD_W-1:0] CMD_PL_FLAG     = 5'd7;
	localparam logic [CMD_W-1:0] CMD_B_ROOT      = 5'd8;
	localparam logic [CMD_W-1:0] CMD_B_LDP       = 5'd9;
	localparam logic [CMD_W-1:0] CMD_B_ROOT_SCAN = 5'd10;
	localparam logic [CMD_W-1:0] CMD_B_POP       = 5'd11;
	localparam logic [CMD_W-1:0] CMD_B_GETP      = 5'd12;
	localparam logic [CMD_W-1:0] CMD_B_GETF      = 5'd13;
	localparam logic [CMD_W-1:0] CMD_B_LDF       = 5'd14;
	localparam logic [CMD_W-1:0] CMD_B_SCAN      = 5'd15;
	localparam logic [CMD_W-1:0] CMD_B_WB        = 5'd16;
	localparam logic [CMD_W-1:0] CMD_T_RD        = 5'd17;
	localparam logic [CMD_W-1:0] CMD_T_MOVE      = 5'd18;
	localparam logic [CMD_W-1:0] CMD_T_STEP      = 5'd19;
	localparam logic [CMD_W-1:0] CMD_T_END       = 5'd20;
	localparam logic [CMD_W-1:0] CMD_Q_CHK       = 5'd21;
	localparam logic [CMD_W-1:0] CMD_Q_NODE      = 5'd22;
	localparam logic [CMD_W-1:0] CMD_Q_RES       = 5'd23;
	localparam logic [CMD_W-1:0] CMD_LOAD_OUT    = 5'd24;

	typedef struct packed {
		logic [2:0]       opcode;
		logic [4:0]       letter;
		logic             last_letter;
		logic             count_mode;
		logic [PAT_W-1:0] pattern_index;
	} item_t;

	typedef struct packed {
		logic [COUNT_W-1:0] occurrences;
		logic [1:0]         status;
	} result_t;

	typedef logic [ALPHABET-1:0][NODE_W-1:0] goto_row_t;

	typedef struct packed {
		logic [COUNT_W-1:0] ocount;
		logic [COUNT_W-1:0] ncount;
		logic [LCE_W-1:0]   lce;
		logic               has_o;
		logic               has_n;
		logic [DEPTH_W-1:0] depth;
	} node_row_t;

	typedef struct packed {
		logic              mode;
		logic [NODE_W-1:0] node;
	} pat_row_t;

	typedef struct packed {
		logic [CMD_W-1:0] op;
	} cmd_t;

	typedef struct packed {
		logic [2:0] in_cls;
		logic       clr_last;
		logic       pl_can_step;
		logic       pl_flag;
		logic       scan_last;
		logic       q_empty;
		logic       t_hit;
		logic       t_done;
		logic       q_bad;
		logic       res_pending;
		logic       out_free;
	} sts_t;

	localparam node_row_t NODE_CLEAR = '{ocount: '0, ncount: '0, lce: FAR_BELOW,
		has_o: 1'b0, has_n: 1'b0, depth: '0};

endpackage

`default_nettype wire

/* rtl/aco_ram.sv */
// Generic simple dual-port RAM with one write port and a registered read port.
`default_nettype none

module aco_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

`default_nettype wire

/* rtl/aco_dp.sv */
// Datapath: trie memories, cursors, breadth-first queue and the result register.
`default_nettype none

module aco_dp (
	input  logic             clk,
	input  logic             arst_n,
	input  aco_pkg::cmd_t    cmd,
	output aco_pkg::sts_t    sts,
	input  aco_pkg::item_t   item,
	input  logic             result_stall,
	output logic             result_valid,
	output aco_pkg::result_t result
);

	// Control registers.
	logic [aco_pkg::NODE_W-1:0]     idx_q;
	logic [aco_pkg::PAT_CNT_W-1:0]  pc_q;
	logic [aco_pkg::NODE_CNT_W-1:0] ncnt_q;
	logic [aco_pkg::NODE_W-1:0]     cursor_q;
	logic [aco_pkg::DEPTH_W-1:0]    cdepth_q;
	logic                           failed_q;
	logic                           built_q;
	logic [aco_pkg::NODE_W-1:0]     match_q;
	logic [aco_pkg::POS_W-1:0]      pos_q;
	logic [aco_pkg::NODE_W-1:0]     head_q;
	logic [aco_pkg::NODE_W-1:0]     tail_q;
	logic [aco_pkg::LETTER_W-1:0]   col_q;
	logic [aco_pkg::DEPTH_W-1:0]    steps_q;
	logic                           res_pend_q;
	logic                           out_valid_q;

	// Payload registers.
	aco_pkg::item_t             item_q;
	aco_pkg::goto_row_t         rowp_q;
	aco_pkg::goto_row_t         rowf_q;
	logic [aco_pkg::NODE_W-1:0] p_q;
	logic [aco_pkg::NODE_W-1:0] tp_q;
	logic                       mode_sel_q;
	aco_pkg::result_t           res_q;
	aco_pkg::result_t           out_q;

	// Memory ports.
	logic                       goto_we, goto_re;
	logic [aco_pkg::NODE_W-1:0] goto_waddr, goto_raddr;
	aco_pkg::goto_row_t         goto_wdata, goto_rdata;
	logic                       node_we, node_re;
	logic [aco_pkg::NODE_W-1:0] node_waddr, node_raddr;
	aco_pkg::node_row_t         node_wdata, node_rdata;
	logic                       fail_we, fail_re;
	logic [aco_pkg::NODE_W-1:0] fail_waddr, fail_raddr;
	logic [aco_pkg::NODE_W-1:0] fail_wdata, fail_rdata;
	logic                       q_we, q_re;
	logic [aco_pkg::NODE_W-1:0] q_waddr, q_raddr, q_wdata, q_rdata;
	logic                       pat_we, pat_re;
	logic [aco_pkg::PAT_W-1:0]  pat_waddr, pat_raddr;
	aco_pkg::pat_row_t          pat_wdata, pat_rdata;

	// Derived values.
	logic                           letter_ok;
	logic [aco_pkg::NODE_W-1:0]     child;
	logic                           node_room;
	aco_pkg::goto_row_t             goto_new;
	aco_pkg::node_row_t             new_node_row;
	aco_pkg::node_row_t             flag_row;
	aco_pkg::node_row_t             step_row;
	logic [aco_pkg::NODE_W-1:0]     scan_child;
	logic [aco_pkg::LCE_W:0]        lce_ext;
	logic signed [aco_pkg::LCE_W:0] end_lhs;
	logic signed [aco_pkg::LCE_W:0] end_rhs;
	logic                           pat_room;

	always_comb begin
		letter_ok  = item.letter < aco_pkg::LETTER_W'(aco_pkg::ALPHABET);
		child      = goto_rdata[item_q.letter];
		scan_child = rowp_q[col_q];
		node_room  = ncnt_q < aco_pkg::NODE_CNT_W'(aco_pkg::NODES);
		pat_room   = pc_q < aco_pkg::PAT_CNT_W'(aco_pkg::MAX_PATTERNS);

		goto_new                 = goto_rdata;
		goto_new[item_q.letter]  = ncnt_q[aco_pkg::NODE_W-1:0];
		new_node_row             = aco_pkg::NODE_CLEAR;
		new_node_row.depth       = cdepth_q + aco_pkg::DEPTH_W'(1);

		flag_row = node_rdata;
		if (item_q.count_mode) begin
			flag_row.has_n = 1'b1;
		end else begin
			flag_row.has_o = 1'b1;
		end

		// A non-overlapping pattern counts only once its previous end plus its length
		// has been reached by the current position.
		lce_ext = {node_rdata.lce[aco_pkg::LCE_W-1], node_rdata.lce};
		end_lhs = $signed(lce_ext)
			+ $signed({{(aco_pkg::LCE_W + 1 - aco_pkg::DEPTH_W){1'b0}}, node_rdata.depth});
		end_rhs = $signed({2'b00, pos_q});
		step_row = node_rdata;
		if (node_rdata.has_o && (node_rdata.ocount != aco_pkg::COUNT_MAX)) begin
			step_row.ocount = node_rdata.ocount + aco_pkg::COUNT_W'(1);
		end
		if (node_rdata.has_n && (end_lhs <= end_rhs)) begin
			step_row.lce = {1'b0, pos_q};
			if (node_rdata.ncount != aco_pkg::COUNT_MAX) begin
				step_row.ncount = node_rdata.ncount + aco_pkg::COUNT_W'(1);
			end
		end

		case (item.opcode)
			aco_pkg::OP_CLEAR:   sts.in_cls = aco_pkg::CLS_CLEAR;
			aco_pkg::OP_PATTERN: sts.in_cls = (letter_ok && !built_q) ? aco_pkg::CLS_PATTERN
			                                                          : aco_pkg::CLS_NONE;
			aco_pkg::OP_BUILD:   sts.in_cls = built_q ? aco_pkg::CLS_NONE : aco_pkg::CLS_BUILD;
			aco_pkg::OP_TEXT:    sts.in_cls = letter_ok ? aco_pkg::CLS_TEXT : aco_pkg::CLS_NONE;
			aco_pkg::OP_QUERY:   sts.in_cls = aco_pkg::CLS_QUERY;
			default:             sts.in_cls = aco_pkg::CLS_NONE;
		endcase

		sts.clr_last    = idx_q == aco_pkg::NODE_W'(aco_pkg::NODES - 1);
		sts.pl_can_step = !failed_q && (cdepth_q < aco_pkg::DEPTH_W'(aco_pkg::MAX_PATTERN_LEN));
		sts.pl_flag     = item_q.last_letter && !failed_q && pat_room;
		sts.scan_last   = col_q == aco_pkg::LETTER_W'(aco_pkg::ALPHABET - 1);
		sts.q_empty     = head_q == tail_q;
		sts.t_hit       = child != '0;
		sts.t_done      = (fail_rdata == '0)
			|| (steps_q == aco_pkg::DEPTH_W'(aco_pkg::MAX_PATTERN_LEN - 1));
		sts.q_bad       = {1'b0, item_q.pattern_index} >= pc_q;
		sts.res_pending = res_pend_q;
		sts.out_free    = !out_valid_q || !result_stall;
	end

	always_comb begin
		goto_we    = 1'b0;
		goto_waddr = idx_q;
		goto_wdata = '0;
		goto_re    = 1'b0;
		goto_raddr = cursor_q;
		node_we    = 1'b0;
		node_waddr = idx_q;
		node_wdata = aco_pkg::NODE_CLEAR;
		node_re    = 1'b0;
		node_raddr = cursor_q;
		fail_we    = 1'b0;
		fail_waddr = idx_q;
		fail_wdata = '0;
		fail_re    = 1'b0;
		fail_raddr = q_rdata;
		q_we       = 1'b0;
		q_waddr    = tail_q;
		q_wdata    = scan_child;
		q_re       = 1'b0;
		q_raddr    = head_q;
		pat_we     = 1'b0;
		pat_waddr  = pc_q[aco_pkg::PAT_W-1:0];
		pat_wdata  = '{mode: item_q.count_mode, node: cursor_q};
		pat_re     = 1'b0;
		pat_raddr  = item_q.pattern_index;
		case (cmd.op)
			aco_pkg::CMD_CLR_STEP: begin
				goto_we = 1'b1;
				node_we = 1'b1;
				fail_we = 1'b1;
			end
			aco_pkg::CMD_PL_RD: begin
				goto_re = sts.pl_can_step;
			end
			aco_pkg::CMD_PL_EV: begin
				if ((child == '0) && node_room) begin
					goto_we    = 1'b1;
					goto_waddr = cursor_q;
					goto_wdata = goto_new;
					node_we    = 1'b1;
					node_waddr = ncnt_q[aco_pkg::NODE_W-1:0];
					node_wdata = new_node_row;
				end
			end
			aco_pkg::CMD_PL_LAST: begin
				if (sts.pl_flag) begin
					pat_we  = 1'b1;
					node_re = 1'b1;
				end
			end
			aco_pkg::CMD_PL_FLAG: begin
				node_we    = 1'b1;
				node_waddr = cursor_q;
				node_wdata = flag_row;
			end
			aco_pkg::CMD_B_ROOT: begin
				goto_re    = 1'b1;
				goto_raddr = '0;
			end
			aco_pkg::CMD_B_ROOT_SCAN: begin
				q_we = scan_child != '0;
			end
			aco_pkg::CMD_B_POP: begin
				q_re = !sts.q_empty;
			end
			aco_pkg::CMD_B_GETP: begin
				fail_re    = 1'b1;
				goto_re    = 1'b1;
				goto_raddr = q_rdata;
			end
			aco_pkg::CMD_B_GETF: begin
				goto_re    = 1'b1;
				goto_raddr = fail_rdata;
			end
			aco_pkg::CMD_B_SCAN: begin
				if (scan_child != '0) begin
					fail_we    = 1'b1;
					fail_waddr = scan_child;
					fail_wdata = rowf_q[col_q];
					q_we       = 1'b1;
				end
			end
			aco_pkg::CMD_B_WB: begin
				goto_we    = 1'b1;
				goto_waddr = p_q;
				goto_wdata = rowp_q;
			end
			aco_pkg::CMD_T_RD: begin
				goto_re    = 1'b1;
				goto_raddr = match_q;
			end
			aco_pkg::CMD_T_MOVE: begin
				node_re    = sts.t_hit;
				node_raddr = child;
				fail_re    = sts.t_hit;
				fail_raddr = child;
			end
			aco_pkg::CMD_T_STEP: begin
				node_we    = 1'b1;
				node_waddr = tp_q;
				node_wdata = step_row;
				node_re    = !sts.t_done;
				node_raddr = fail_rdata;
				fail_re    = !sts.t_done;
				fail_raddr = fail_rdata;
			end
			aco_pkg::CMD_Q_CHK: begin
				pat_re = !sts.q_bad;
			end
			aco_pkg::CMD_Q_NODE: begin
				node_re    = 1'b1;
				node_raddr = pat_rdata.node;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q      <= '0;
			pc_q       <= '0;
			ncnt_q     <= aco_pkg::NODE_CNT_W'(1);
			cursor_q   <= '0;
			cdepth_q   <= '0;
			failed_q   <= 1'b0;
			built_q    <= 1'b0;
			match_q    <= '0;
			pos_q      <= '0;
			head_q     <= '0;
			tail_q     <= '0;
			col_q      <= '0;
			steps_q    <= '0;
			res_pend_q <= 1'b0;
		end else begin
			case (cmd.op)
				aco_pkg::CMD_CLR_START: begin
					idx_q      <= '0;
					pc_q       <= '0;
					ncnt_q     <= aco_pkg::NODE_CNT_W'(1);
					cursor_q   <= '0;
					cdepth_q   <= '0;
					failed_q   <= 1'b0;
					built_q    <= 1'b0;
					match_q    <= '0;
					pos_q      <= '0;
					head_q     <= '0;
					tail_q     <= '0;
					col_q      <= '0;
					steps_q    <= '0;
					res_pend_q <= 1'b0;
				end
				aco_pkg::CMD_CLR_STEP: idx_q <= idx_q + aco_pkg::NODE_W'(1);
				aco_pkg::CMD_CAPTURE:  res_pend_q <= 1'b0;
				aco_pkg::CMD_PL_EV: begin
					if (child == '0) begin
						if (node_room) begin
							ncnt_q   <= ncnt_q + aco_pkg::NODE_CNT_W'(1);
							cursor_q <= ncnt_q[aco_pkg::NODE_W-1:0];
							cdepth_q <= cdepth_q + aco_pkg::DEPTH_W'(1);
						end else begin
							failed_q   <= 1'b1;
							res_pend_q <= 1'b1;
						end
					end else begin
						cursor_q <= child;
						cdepth_q <= cdepth_q + aco_pkg::DEPTH_W'(1);
					end
				end
				aco_pkg::CMD_PL_LAST: begin
					if (item_q.last_letter) begin
						if (sts.pl_flag) begin
							pc_q <= pc_q + aco_pkg::PAT_CNT_W'(1);
						end else begin
							if (!failed_q) begin
								res_pend_q <= 1'b1;
							end
							cursor_q <= '0;
							cdepth_q <= '0;
							failed_q <= 1'b0;
						end
					end
				end
				aco_pkg::CMD_PL_FLAG: begin
					cursor_q <= '0;
					cdepth_q <= '0;
					failed_q <= 1'b0;
				end
				aco_pkg::CMD_B_ROOT: begin
					built_q <= 1'b1;
					head_q  <= '0;
					tail_q  <= '0;
				end
				aco_pkg::CMD_B_LDP, aco_pkg::CMD_B_LDF: col_q <= '0;
				aco_pkg::CMD_B_ROOT_SCAN, aco_pkg::CMD_B_SCAN: begin
					if (scan_child != '0) begin
						tail_q <= tail_q + aco_pkg::NODE_W'(1);
					end
					col_q <= col_q + aco_pkg::LETTER_W'(1);
				end
				aco_pkg::CMD_B_POP: begin
					if (!sts.q_empty) begin
						head_q <= head_q + aco_pkg::NODE_W'(1);
					end
				end
				aco_pkg::CMD_T_MOVE: begin
					match_q <= child;
					steps_q <= '0;
				end
				aco_pkg::CMD_T_STEP: steps_q <= steps_q + aco_pkg::DEPTH_W'(1);
				aco_pkg::CMD_T_END: begin
					if (pos_q != '1) begin
						pos_q <= pos_q + aco_pkg::POS_W'(1);
					end
				end
				aco_pkg::CMD_Q_CHK: begin
					if (sts.q_bad) begin
						res_pend_q <= 1'b1;
					end
				end
				aco_pkg::CMD_Q_RES:    res_pend_q <= 1'b1;
				aco_pkg::CMD_LOAD_OUT: res_pend_q <= 1'b0;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else begin
			out_valid_q <= (cmd.op == aco_pkg::CMD_LOAD_OUT) || (out_valid_q && result_stall);
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			aco_pkg::CMD_CAPTURE: item_q <= item;
			aco_pkg::CMD_PL_EV: begin
				if ((child == '0) && !node_room) begin
					res_q <= '{occurrences: '0, status: aco_pkg::ST_TRIE_FULL};
				end
			end
			aco_pkg::CMD_PL_LAST: begin
				if (item_q.last_letter && !failed_q && !pat_room) begin
					res_q <= '{occurrences: '0, status: aco_pkg::ST_TRIE_FULL};
				end
			end
			aco_pkg::CMD_B_LDP:  rowp_q <= goto_rdata;
			aco_pkg::CMD_B_GETP: p_q <= q_rdata;
			aco_pkg::CMD_B_GETF: rowp_q <= goto_rdata;
			aco_pkg::CMD_B_LDF:  rowf_q <= goto_rdata;
			aco_pkg::CMD_B_SCAN: begin
				// A missing edge takes the edge of the fail target.
				if (scan_child == '0) begin
					rowp_q[col_q] <= rowf_q[col_q];
				end
			end
			aco_pkg::CMD_T_MOVE: tp_q <= child;
			aco_pkg::CMD_T_STEP: tp_q <= fail_rdata;
			aco_pkg::CMD_Q_CHK: begin
				if (sts.q_bad) begin
					res_q <= '{occurrences: '0, status: aco_pkg::ST_BAD_INDEX};
				end
			end
			aco_pkg::CMD_Q_NODE: mode_sel_q <= pat_rdata.mode;
			aco_pkg::CMD_Q_RES: begin
				res_q <= '{occurrences: mode_sel_q ? node_rdata.ncount : node_rdata.ocount,
					status: aco_pkg::ST_ANSWER};
			end
			aco_pkg::CMD_LOAD_OUT: out_q <= res_q;
			default: begin
			end
		endcase
	end

	assign result_valid = out_valid_q;
	assign result       = out_q;

	aco_ram #(.WIDTH($bits(aco_pkg::goto_row_t)), .DEPTH(aco_pkg::NODES)) u_goto_ram (
		.clk(clk), .wr_en(goto_we), .wr_addr(goto_waddr), .wr_data(goto_wdata),
		.rd_en(goto_re), .rd_addr(goto_raddr), .rd_data(goto_rdata)
	);

	aco_ram #(.WIDTH($bits(aco_pkg::node_row_t)), .DEPTH(aco_pkg::NODES)) u_node_ram (
		.clk(clk), .wr_en(node_we), .wr_addr(node_waddr), .wr_data(node_wdata),
		.rd_en(node_re), .rd_addr(node_raddr), .rd_data(node_rdata)
	);

	aco_ram #(.WIDTH(aco_pkg::NODE_W), .DEPTH(aco_pkg::NODES)) u_fail_ram (
		.clk(clk), .wr_en(fail_we), .wr_addr(fail_waddr), .wr_data(fail_wdata),
		.rd_en(fail_re), .rd_addr(fail_raddr), .rd_data(fail_rdata)
	);

	aco_ram #(.WIDTH(aco_pkg::NODE_W), .DEPTH(aco_pkg::NODES)) u_queue_ram (
		.clk(clk), .wr_en(q_we), .wr_addr(q_waddr), .wr_data(q_wdata),
		.rd_en(q_re), .rd_addr(q_raddr), .rd_data(q_rdata)
	);

	aco_ram #(.WIDTH($bits(aco_pkg::pat_row_t)), .DEPTH(aco_pkg::MAX_PATTERNS)) u_pat_ram (
		.clk(clk), .wr_en(pat_we), .wr_addr(pat_waddr), .wr_data(pat_wdata),
		.rd_en(pat_re), .rd_addr(pat_raddr), .rd_data(pat_rdata)
	);

endmodule

`default_nettype wire

/* rtl/aco_ctrl.sv */
// Controller state machine that sequences every operation of the counter.
`default_nettype none

module aco_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          item_valid,
	output logic          item_stall,
	output aco_pkg::cmd_t cmd,
	input  aco_pkg::sts_t sts
);

	localparam logic [4:0] S_CLR     = 5'd0;
	localparam logic [4:0] S_IDLE    = 5'd1;
	localparam logic [4:0] S_PL_RD   = 5'd2;
	localparam logic [4:0] S_PL_EV   = 5'd3;
	localparam logic [4:0] S_PL_LAST = 5'd4;
	localparam logic [4:0] S_PL_FLAG = 5'd5;
	localparam logic [4:0] S_RESP    = 5'd6;
	localparam logic [4:0] S_B_ROOT  = 5'd7;
	localparam logic [4:0] S_B_LDP   = 5'd8;
	localparam logic [4:0] S_B_RSCAN = 5'd9;
	localparam logic [4:0] S_B_POP   = 5'd10;
	localparam logic [4:0] S_B_GETP  = 5'd11;
	localparam logic [4:0] S_B_GETF  = 5'd12;
	localparam logic [4:0] S_B_LDF   = 5'd13;
	localparam logic [4:0] S_B_SCAN  = 5'd14;
	localparam logic [4:0] S_B_WB    = 5'd15;
	localparam logic [4:0] S_T_RD    = 5'd16;
	localparam logic [4:0] S_T_MOVE  = 5'd17;
	localparam logic [4:0] S_T_STEP  = 5'd18;
	localparam logic [4:0] S_T_END   = 5'd19;
	localparam logic [4:0] S_Q_CHK   = 5'd20;
	localparam logic [4:0] S_Q_NODE  = 5'd21;
	localparam logic [4:0] S_Q_RES   = 5'd22;

	logic [4:0] state_q;
	logic [4:0] state_d;

	assign item_stall = state_q != S_IDLE;

	always_comb begin
		state_d = state_q;
		cmd.op  = aco_pkg::CMD_NOP;
		unique case (state_q)
			S_CLR: begin
				cmd.op = aco_pkg::CMD_CLR_STEP;
				if (sts.clr_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (item_valid) begin
					cmd.op = aco_pkg::CMD_CAPTURE;
					unique case (sts.in_cls)
						aco_pkg::CLS_CLEAR: begin
							cmd.op  = aco_pkg::CMD_CLR_START;
							state_d = S_CLR;
						end
						aco_pkg::CLS_PATTERN: state_d = S_PL_RD;
						aco_pkg::CLS_BUILD:   state_d = S_B_ROOT;
						aco_pkg::CLS_TEXT:    state_d = S_T_RD;
						aco_pkg::CLS_QUERY:   state_d = S_Q_CHK;
						default:              state_d = S_IDLE;
					endcase
				end
			end
			S_PL_RD: begin
				cmd.op  = aco_pkg::CMD_PL_RD;
				state_d = sts.pl_can_step ? S_PL_EV : S_PL_LAST;
			end
			S_PL_EV: begin
				cmd.op  = aco_pkg::CMD_PL_EV;
				state_d = S_PL_LAST;
			end
			S_PL_LAST: begin
				cmd.op  = aco_pkg::CMD_PL_LAST;
				state_d = sts.pl_flag ? S_PL_FLAG : S_RESP;
			end
			S_PL_FLAG: begin
				cmd.op  = aco_pkg::CMD_PL_FLAG;
				state_d = S_RESP;
			end
			S_RESP: begin
				if (!sts.res_pending) begin
					state_d = S_IDLE;
				end else if (sts.out_free) begin
					cmd.op  = aco_pkg::CMD_LOAD_OUT;
					state_d = S_IDLE;
				end
			end
			S_B_ROOT: begin
				cmd.op  = aco_pkg::CMD_B_ROOT;
				state_d = S_B_LDP;
			end
			S_B_LDP: begin
				cmd.op  = aco_pkg::CMD_B_LDP;
				state_d = S_B_RSCAN;
			end
			S_B_RSCAN: begin
				cmd.op = aco_pkg::CMD_B_ROOT_SCAN;
				if (sts.scan_last) begin
					state_d = S_B_POP;
				end
			end
			S_B_POP: begin
				cmd.op  = aco_pkg::CMD_B_POP;
				state_d = sts.q_empty ? S_IDLE : S_B_GETP;
			end
			S_B_GETP: begin
				cmd.op  = aco_pkg::CMD_B_GETP;
				state_d = S_B_GETF;
			end
			S_B_GETF: begin
				cmd.op  = aco_pkg::CMD_B_GETF;
				state_d = S_B_LDF;
			end
			S_B_LDF: begin
				cmd.op  = aco_pkg::CMD_B_LDF;
				state_d = S_B_SCAN;
			end
			S_B_SCAN: begin
				cmd.op = aco_pkg::CMD_B_SCAN;
				if (sts.scan_last) begin
					state_d = S_B_WB;
				end
			end
			S_B_WB: begin
				cmd.op  = aco_pkg::CMD_B_WB;
				state_d = S_B_POP;
			end
			S_T_RD: begin
				cmd.op  = aco_pkg::CMD_T_RD;
				state_d = S_T_MOVE;
			end
			S_T_MOVE: begin
				cmd.op  = aco_pkg::CMD_T_MOVE;
				state_d = sts.t_hit ? S_T_STEP : S_T_END;
			end
			S_T_STEP: begin
				cmd.op = aco_pkg::CMD_T_STEP;
				if (sts.t_done) begin
					state_d = S_T_END;
				end
			end
			S_T_END: begin
				cmd.op  = aco_pkg::CMD_T_END;
				state_d = S_IDLE;
			end
			S_Q_CHK: begin
				cmd.op  = aco_pkg::CMD_Q_CHK;
				state_d = sts.q_bad ? S_RESP : S_Q_NODE;
			end
			S_Q_NODE: begin
				cmd.op  = aco_pkg::CMD_Q_NODE;
				state_d = S_Q_RES;
			end
			S_Q_RES: begin
				cmd.op  = aco_pkg::CMD_Q_RES;
				state_d = S_RESP;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

`default_nettype wire

/* rtl/aho_corasick_occurrence_counter_top.sv */
// Top level of the multi-pattern occurrence counter: controller plus datapath.
//
// The block takes one item per transfer on the item channel (valid/stall) and
// returns at most one result per item on the result channel (valid/stall).
// Opcodes: clear, pattern letter, build links, text letter, query pattern.
// Each item is worked on alone; item_stall is high until its work is done.
// Pattern letter: goto read, optional step, last-letter check, optional flag
// write, response. Query: index check, node read and result if the index
// is loaded, then a response that loads the output register; the result
// shows valid on the following cycle. Text letter: goto read, move, one
// step per fail-chain node, end; node memory is read and written once per
// chain step. Build links: root row, then each queued node, bound by the one
// goto row port and letter-by-letter column scan. Clear and reset both run
// a clearing pass over node, goto and fail memories; no item is taken meanwhile.
// A result sits in an output register. If the receiver stalls, the result
// holds and a later item that yields a result waits for the register to
// empty; items without results still proceed.
// Errors: status 1 when the trie or the pattern table is full, status 2 for
// a query of a pattern index that was never loaded.
`default_nettype none

module aho_corasick_occurrence_counter_top (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             item_valid,
	output logic             item_stall,
	input  aco_pkg::item_t   item,
	output logic             result_valid,
	input  logic             result_stall,
	output aco_pkg::result_t result
);

	aco_pkg::cmd_t cmd;
	aco_pkg::sts_t sts;

	// The controller owns the item handshake and steps the datapath.
	aco_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.cmd(cmd),
		.sts(sts)
	);

	// The datapath holds all memories and the result register.
	aco_dp u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd),
		.sts(sts),
		.item(item),
		.result_stall(result_stall),
		.result_valid(result_valid),
		.result(result)
	);

endmodule

`default_nettype wire

/* rtl/aco_chk.sv */
// Port-level checker for the occurrence counter and its bind to the top level.
`default_nettype none

module aco_chk (
	input logic             clk,
	input logic             arst_n,
	input logic             item_valid,
	input logic             item_stall,
	input aco_pkg::item_t   item,
	input logic             result_valid,
	input logic             result_stall,
	input aco_pkg::result_t result
);

	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(result))
		else $error("stalled result changed");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (result.status == aco_pkg::ST_ANSWER)
			|| (result.status == aco_pkg::ST_TRIE_FULL)
			|| (result.status == aco_pkg::ST_BAD_INDEX))
		else $error("unknown status code");

	a_error_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (result.status != aco_pkg::ST_ANSWER) |-> result.occurrences == '0)
		else $error("error result with nonzero count");

	a_clear_busy: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && !item_stall && (item.opcode == aco_pkg::OP_CLEAR) |=> item_stall)
		else $error("clear did not start a clearing pass");

	a_unknown_op: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && !item_stall && (item.opcode > aco_pkg::OP_QUERY) |=> !item_stall)
		else $error("unknown opcode did not pass straight through");

endmodule

bind aho_corasick_occurrence_counter_top aco_chk u_aco_chk (.*);

`default_nettype wire
